### rtl/core/tscm_pkg.sv
// ----------------------------------------------------------------------------
// tscm_pkg: shared types and constants of the three stop colour map
// Normalisation format, register indexes, the beat carried along the divider
// chain and the colour stop table.
// ----------------------------------------------------------------------------
`default_nettype none

package tscm_pkg;

   // fraction bits of the normalised sample
   localparam int NORM_FRAC_BITS = 16;
   localparam int NORM_W         = NORM_FRAC_BITS + 1;

   // sample and range width, and width of a positive span or remainder
   localparam int SAMPLE_W = 32;
   localparam int DIFF_W   = SAMPLE_W + 1;

   // blend arithmetic width: colour * 2^(F-1) plus rounding fits with margin
   localparam int BLEND_W = NORM_FRAC_BITS + 10;

   localparam int CHANNEL_W = 8;
   localparam int RGB_W     = 3 * CHANNEL_W;

   // normalised one half and one
   localparam logic [NORM_W-1:0] NORM_HALF = NORM_W'(1) << (NORM_FRAC_BITS - 1);
   localparam logic [NORM_W-1:0] NORM_ONE  = NORM_W'(1) << NORM_FRAC_BITS;

   // configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_MINIMUM = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_MAXIMUM = CSR_INDEX_W'(1);

   // stop and channel codes
   localparam logic [1:0] STOP_LOW  = 2'd0;
   localparam logic [1:0] STOP_MID  = 2'd1;
   localparam logic [1:0] STOP_HIGH = 2'd2;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // one beat travelling down the divider chain
   typedef struct packed {
      logic                      valid;
      logic                      special;   // normalised value already known
      logic [NORM_W-1:0]         special_n;
      logic [SAMPLE_W-1:0]       span;      // positive divisor
      logic [SAMPLE_W-1:0]       rem;       // partial remainder, below span unless special
      logic [NORM_FRAC_BITS-1:0] quot;      // quotient bits so far
   } tscm_beat_type;

   // colour stop table
   function automatic logic [CHANNEL_W-1:0] stop_channel(input logic [1:0] stop,
                                                         input logic [1:0] ch);
      logic [CHANNEL_W-1:0] value;
      value = '0;
      case (stop)
         STOP_LOW: begin
            case (ch)
               CH_RED:   value = 8'd8;
               CH_GREEN: value = 8'd29;
               CH_BLUE:  value = 8'd55;
               default:  value = '0;
            endcase
         end
         STOP_MID: begin
            case (ch)
               CH_RED:   value = 8'd23;
               CH_GREEN: value = 8'd132;
               CH_BLUE:  value = 8'd160;
               default:  value = '0;
            endcase
         end
         STOP_HIGH: begin
            case (ch)
               CH_RED:   value = 8'd250;
               CH_GREEN: value = 8'd221;
               CH_BLUE:  value = 8'd90;
               default:  value = '0;
            endcase
         end
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

### rtl/core/tscm_prep.sv
// ----------------------------------------------------------------------------
// tscm_prep: offset and span of one sample
// Forms sample - minimum and maximum - minimum, folds a reversed range and
// settles the flat, clamped and degenerate cases before the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tscm_prep (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             sample_valid,
   input  wire logic [tscm_pkg::SAMPLE_W-1:0]    sample,
   input  wire logic [tscm_pkg::SAMPLE_W-1:0]    range_minimum,
   input  wire logic [tscm_pkg::SAMPLE_W-1:0]    range_maximum,
   output tscm_pkg::tscm_beat_type               beat_out
);
   import tscm_pkg::*;

   logic signed [DIFF_W-1:0] span_s;
   logic signed [DIFF_W-1:0] off_s;
   logic signed [DIFF_W-1:0] span_abs;
   logic signed [DIFF_W-1:0] off_abs;
   tscm_beat_type            beat_in;
   tscm_beat_type            beat_ff;

   // exact differences, reversed range folded by negating both
   always_comb begin
      span_s = signed'({range_maximum[SAMPLE_W-1], range_maximum})
             - signed'({range_minimum[SAMPLE_W-1], range_minimum});
      off_s  = signed'({sample[SAMPLE_W-1], sample})
             - signed'({range_minimum[SAMPLE_W-1], range_minimum});
      if (span_s[DIFF_W-1]) begin
         span_abs = -span_s;
         off_abs  = -off_s;
      end else begin
         span_abs = span_s;
         off_abs  = off_s;
      end
   end

   // classify the sample
   always_comb begin
      beat_in.valid     = sample_valid;
      beat_in.special   = 1'b1;
      beat_in.special_n = '0;
      beat_in.span      = span_abs[SAMPLE_W-1:0];
      beat_in.rem       = off_abs[SAMPLE_W-1:0];
      beat_in.quot      = '0;
      if (span_s == '0) begin
         beat_in.special_n = NORM_HALF;
      end else if (off_abs[DIFF_W-1] || off_abs == '0) begin
         beat_in.special_n = '0;
      end else if (off_abs >= span_abs) begin
         beat_in.special_n = NORM_ONE;
      end else begin
         beat_in.special = 1'b0;
      end
   end

   // first register of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_out = beat_ff;

endmodule

`default_nettype wire

### rtl/core/tscm_div_cell.sv
// ----------------------------------------------------------------------------
// tscm_div_cell: one restoring division step
// Doubles the partial remainder, subtracts the span where it fits and
// shifts the resulting quotient bit in; passes the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tscm_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  tscm_pkg::tscm_beat_type  beat_in,
   output tscm_pkg::tscm_beat_type  beat_out
);
   import tscm_pkg::*;

   logic [DIFF_W-1:0] doubled;
   logic [DIFF_W-1:0] span_ext;
   logic              fits;
   tscm_beat_type     step_in;
   tscm_beat_type     beat_ff;

   // one quotient bit
   always_comb begin
      doubled  = {beat_in.rem, 1'b0};
      span_ext = {1'b0, beat_in.span};
      fits     = doubled >= span_ext;
      step_in  = beat_in;
      if (fits) begin
         step_in.rem = SAMPLE_W'(doubled - span_ext);
      end else begin
         step_in.rem = doubled[SAMPLE_W-1:0];
      end
      step_in.quot = {beat_in.quot[NORM_FRAC_BITS-2:0], fits};
   end

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= step_in;
      end
   end

   assign beat_out = beat_ff;

endmodule

`default_nettype wire

### rtl/core/tscm_blend.sv
// ----------------------------------------------------------------------------
// tscm_blend: segment selection and channel interpolation
// Picks the lower or upper segment from the normalised value, blends the
// two stops of each channel with rounding and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tscm_blend (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  tscm_pkg::tscm_beat_type            beat_in,
   output logic                               rgb_valid,
   output logic [tscm_pkg::RGB_W-1:0]         rgb
);
   import tscm_pkg::*;

   logic [NORM_W-1:0]           norm;
   logic [NORM_FRAC_BITS-1:0]   frac;
   logic [1:0]                  stop_a;
   logic [1:0]                  stop_b;
   logic [CHANNEL_W-1:0]        first  [3];
   logic [CHANNEL_W-1:0]        second [3];
   logic signed [9:0]           delta  [3];
   logic signed [BLEND_W-1:0]   total  [3];
   logic [RGB_W-1:0]            rgb_in;
   logic [RGB_W-1:0]            rgb_ff;
   logic                        valid_ff;

   // normalised value and segment
   always_comb begin
      norm = beat_in.special ? beat_in.special_n : {1'b0, beat_in.quot};
      if (norm <= NORM_HALF) begin
         stop_a = STOP_LOW;
         stop_b = STOP_MID;
         frac   = norm[NORM_FRAC_BITS-1:0];
      end else begin
         stop_a = STOP_MID;
         stop_b = STOP_HIGH;
         frac   = NORM_FRAC_BITS'(norm - NORM_HALF);
      end
   end

   // per channel blend with round half up
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         first[c]  = stop_channel(stop_a, 2'(c));
         second[c] = stop_channel(stop_b, 2'(c));
         delta[c]  = signed'({2'b00, second[c]}) - signed'({2'b00, first[c]});
         total[c]  = (signed'(BLEND_W'(first[c])) <<< (NORM_FRAC_BITS - 1))
                   + signed'(BLEND_W'(frac)) * BLEND_W'(delta[c])
                   + (signed'(BLEND_W'(1)) <<< (NORM_FRAC_BITS - 2));
         rgb_in[c*CHANNEL_W +: CHANNEL_W] = total[c][NORM_FRAC_BITS-1 +: CHANNEL_W];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= beat_in.valid;
         rgb_ff   <= rgb_in;
      end
   end

   assign rgb_valid = valid_ff;
   assign rgb       = rgb_ff;

endmodule

`default_nettype wire

### rtl/core/three_stop_colour_map.sv
// ----------------------------------------------------------------------------
// three_stop_colour_map: scalar sample to RGB colour
// Normalises a sample against the configured range through a chain of
// restoring division cells and blends between three colour stops.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   req_      in         sample (32 bit signed)
//   rsp_      out        red, green, blue (8 bit each)
//   csr_      in         register index, 32 bit write data
//
// One sample per clock is accepted while the chain is not stalled. A result
// passes through one prep cell, one division cell per quotient bit and
// the blend register.
// The whole chain stalls together while a result beat waits on rsp_tready.
// Reset clears the valid bits of the chain and both range registers.
// ----------------------------------------------------------------------------
`default_nettype none

module three_stop_colour_map (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample: [31:0] sample
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tscm_pkg::SAMPLE_W-1:0]     req_tdata,
   // colour: [7:0] red, [15:8] green, [23:16] blue
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [tscm_pkg::RGB_W-1:0]             rsp_tdata,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tscm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tscm_pkg::SAMPLE_W-1:0]     csr_data
);
   import tscm_pkg::*;

   logic                advance;
   logic [SAMPLE_W-1:0] range_minimum_ff;
   logic [SAMPLE_W-1:0] range_maximum_ff;
   tscm_beat_type       chain [NORM_FRAC_BITS+1];

   // whole chain moves when the result slot is free or being emptied
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   // range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_minimum_ff <= '0;
         range_maximum_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RANGE_MINIMUM: range_minimum_ff <= csr_data;
            REG_RANGE_MAXIMUM: range_maximum_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // offset and span
   tscm_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sample_valid  (req_tvalid),
      .sample        (req_tdata),
      .range_minimum (range_minimum_ff),
      .range_maximum (range_maximum_ff),
      .beat_out      (chain[0])
   );

   // division chain, one quotient bit per cell
   for (genvar i = 0; i < NORM_FRAC_BITS; i++) begin : g_cell
      tscm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   // colour blend and result register
   tscm_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .beat_in   (chain[NORM_FRAC_BITS]),
      .rgb_valid (rsp_tvalid),
      .rgb       (rsp_tdata)
   );

   // remainder stays below the span at the head of the chain
   a_rem_head: assert property (@(posedge clock) disable iff (reset)
      chain[0].valid && !chain[0].special |-> chain[0].rem < chain[0].span)
      else $error("partial remainder not below span at chain head");

   // remainder stays below the span at the tail of the chain
   a_rem_tail: assert property (@(posedge clock) disable iff (reset)
      chain[NORM_FRAC_BITS].valid && !chain[NORM_FRAC_BITS].special
      |-> chain[NORM_FRAC_BITS].rem < chain[NORM_FRAC_BITS].span)
      else $error("partial remainder not below span at chain tail");

   // a flat range gives the middle stop
   a_mid_stop: assert property (@(posedge clock) disable iff (reset)
      advance && chain[NORM_FRAC_BITS].valid && chain[NORM_FRAC_BITS].special
      && chain[NORM_FRAC_BITS].special_n == NORM_HALF
      |=> rsp_tvalid && rsp_tdata == {8'd160, 8'd132, 8'd23})
      else $error("half value did not give the middle stop");

   // no result beat straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid after reset");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for three_stop_colour_map
// Walks a table of directed samples, then runs random phases at several
// range settings and handshake paces. Every colour beat is checked field by
// field against a table value or a local predictor of the normalise-and-blend arithmetic.
// ----------------------------------------------------------------------------

module tb;

   import tscm_pkg::*;

   // colour beat, red in the lowest byte
   typedef struct packed {
      logic [CHANNEL_W-1:0] blue;
      logic [CHANNEL_W-1:0] green;
      logic [CHANNEL_W-1:0] red;
   } colour_type;

   // one row of the directed table
   typedef struct packed {
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] sample;
      logic                typed;
      colour_type          rgb;
   } dir_row_type;

   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;

   localparam colour_type LOW_RGB  = '{blue: 8'd55,  green: 8'd29,  red: 8'd8};
   localparam colour_type MID_RGB  = '{blue: 8'd160, green: 8'd132, red: 8'd23};
   localparam colour_type HIGH_RGB = '{blue: 8'd90,  green: 8'd221, red: 8'd250};

   localparam logic [SAMPLE_W-1:0] S_MIN = 32'h8000_0000;
   localparam logic [SAMPLE_W-1:0] S_MAX = 32'h7FFF_FFFF;

   localparam int DIR_ROWS      = 25;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 100;
   localparam int SETTLE_CYCLES = NORM_FRAC_BITS + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RGB_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [SAMPLE_W-1:0]    csr_data   = '0;

   // predictor copy of the range registers
   logic signed [SAMPLE_W-1:0] range_lo = '0;
   logic signed [SAMPLE_W-1:0] range_hi = '0;

   colour_type  colour_q [$];
   dir_row_type dir_table [DIR_ROWS];
   pace_type    pace        = PACE_FULL;
   logic        pressure_go = 1'b0;
   int          hold_count  = 0;
   int          quiet_count = 0;
   int          mismatch_count = 0;

   three_stop_colour_map u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] red, [15:8] green, [23:16] blue
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // interpolate one channel on a segment, rounding halves up
   function automatic logic [CHANNEL_W-1:0] blend_channel(input int first, input int second,
                                                          input longint frac);
      longint total;
      total = longint'(first) * (longint'(1) << (NORM_FRAC_BITS - 1))
              + frac * longint'(second - first);
      total = total + (longint'(1) << (NORM_FRAC_BITS - 2));
      return CHANNEL_W'(total >>> (NORM_FRAC_BITS - 1));
   endfunction

   // normalise against the range, pick the segment, blend each channel
   function automatic colour_type predict_colour(input logic signed [SAMPLE_W-1:0] s);
      longint     span, offset, norm, half, frac;
      colour_type base, top, rgb;
      half   = longint'(1) << (NORM_FRAC_BITS - 1);
      span   = longint'(range_hi) - longint'(range_lo);
      offset = longint'(s) - longint'(range_lo);
      if (span == 0) begin
         norm = half;
      end else begin
         // reversed range: flip both so the map runs backwards
         if (span < 0) begin
            span   = -span;
            offset = -offset;
         end
         if (offset <= 0)
            norm = 0;
         else if (offset >= span)
            norm = longint'(1) << NORM_FRAC_BITS;
         else
            norm = (offset << NORM_FRAC_BITS) / span;
      end
      // exactly one half stays on the lower segment
      if (norm > half) begin
         base = MID_RGB;
         top  = HIGH_RGB;
         frac = norm - half;
      end else begin
         base = LOW_RGB;
         top  = MID_RGB;
         frac = norm;
      end
      rgb.red   = blend_channel(int'(base.red),   int'(top.red),   frac);
      rgb.green = blend_channel(int'(base.green), int'(top.green), frac);
      rgb.blue  = blend_channel(int'(base.blue),  int'(top.blue),  frac);
      return rgb;
   endfunction

   // random stall decision for the sender (0) or the receiver (1)
   function automatic bit gap_now(input bit receiver);
      int roll;
      roll = $urandom_range(0, 99);
      if (pace == PACE_BOTH)
         return roll < 27;
      if ((pace == PACE_SEND_GAPS && !receiver) || (pace == PACE_RECV_STALLS && receiver))
         return roll < 46;
      return 1'b0;
   endfunction

   // random sample: mostly inside the range, some at its ends, some anywhere
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      longint base, width, value;
      int     kind;
      base  = (range_lo < range_hi) ? longint'(range_lo) : longint'(range_hi);
      width = longint'(range_hi) - longint'(range_lo);
      if (width < 0)
         width = -width;
      kind = $urandom_range(0, 9);
      if (kind <= 4)
         value = base + (longint'($urandom) % (width + 1));
      else if (kind == 5)
         value = (($urandom_range(0, 1) == 0) ? longint'(range_lo) : longint'(range_hi))
                 + longint'($urandom_range(0, 6)) - 3;
      else if (kind == 6)
         case ($urandom_range(0, 2))
            0:       value = longint'(range_lo);
            1:       value = longint'(range_hi);
            default: value = (longint'(range_lo) + longint'(range_hi)) >>> 1;
         endcase
      else
         value = longint'($urandom);
      return SAMPLE_W'(value);
   endfunction

   // one sample beat; the expected colour is queued when it is taken
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                              input colour_type rgb);
      while (gap_now(1'b0)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      colour_q.push_back(typed ? rgb : predict_colour(s));
   endtask

   // one register write; csr_valid is left high for the caller to drop
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == REG_RANGE_MINIMUM)
         range_lo = d;
      else if (idx == REG_RANGE_MAXIMUM)
         range_hi = d;
   endtask

   // both range registers plus a write to an unused index that must be ignored
   task automatic set_range(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
      write_reg(REG_RANGE_MINIMUM, lo);
      write_reg(REG_RANGE_MAXIMUM, hi);
      write_reg(CSR_INDEX_W'($urandom_range(REG_RANGE_MAXIMUM + 1, 255)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // stop offering samples and let every colour beat come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (colour_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // colour beat checker and receiver pacing
   always @(posedge clock) begin
      colour_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (colour_q.size() == 0) begin
            $display("%0t: colour beat r=%0d g=%0d b=%0d with none expected",
                     $time, got.red, got.green, got.blue);
            mismatch_count++;
         end else begin
            want = colour_q.pop_front();
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue) begin
               $display("%0t: colour mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $time, want.red, want.green, want.blue,
                        got.red, got.green, got.blue);
               mismatch_count++;
            end
         end
      end
      // one long hold-off so the chain fills and backs up the sample side
      if (pressure_go && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !gap_now(1'b1);
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // stimulus
   initial begin
      int                  p, i, sel;
      dir_row_type         row;
      logic [SAMPLE_W-1:0] new_lo, new_hi;

      dir_table = '{
         // reset range: min equals max, everything maps to the middle stop
         '{32'd0, 32'd0, 32'd0,          1'b1, MID_RGB},
         '{32'd0, 32'd0, S_MAX,          1'b1, MID_RGB},
         '{32'd0, 32'd0, S_MIN,          1'b1, MID_RGB},
         // plain range, ends, clamping and exactly one half
         '{32'd0, 32'd1000, 32'd0,       1'b1, LOW_RGB},
         '{32'd0, 32'd1000, 32'd1000,    1'b1, HIGH_RGB},
         '{32'd0, 32'd1000, -32'sd5,     1'b1, LOW_RGB},
         '{32'd0, 32'd1000, 32'd2000,    1'b1, HIGH_RGB},
         '{32'd0, 32'd1000, 32'd500,     1'b1, MID_RGB},
         '{32'd0, 32'd1000, 32'd250,     1'b0, colour_type'('0)},
         '{32'd0, 32'd1000, 32'd750,     1'b0, colour_type'('0)},
         '{32'd0, 32'd1000, 32'd999,     1'b0, colour_type'('0)},
         '{32'd0, 32'd1000, 32'd1,       1'b0, colour_type'('0)},
         // widest span, needs the full 33 bit difference
         '{S_MIN, S_MAX, S_MIN,          1'b1, LOW_RGB},
         '{S_MIN, S_MAX, S_MAX,          1'b1, HIGH_RGB},
         '{S_MIN, S_MAX, 32'd0,          1'b0, colour_type'('0)},
         '{S_MIN, S_MAX, 32'hFFFF_FFFF,  1'b0, colour_type'('0)},
         // reversed widest span
         '{S_MAX, S_MIN, S_MAX,          1'b1, LOW_RGB},
         '{S_MAX, S_MIN, S_MIN,          1'b1, HIGH_RGB},
         '{S_MAX, S_MIN, 32'd0,          1'b0, colour_type'('0)},
         // reversed small range with clamping both sides and its middle
         '{32'd100, -32'sd100, 32'd200,  1'b1, LOW_RGB},
         '{32'd100, -32'sd100, -32'sd200, 1'b1, HIGH_RGB},
         '{32'd100, -32'sd100, 32'd0,    1'b1, MID_RGB},
         // equal non-zero range
         '{-32'sd7, -32'sd7, -32'sd7,    1'b1, MID_RGB},
         '{-32'sd7, -32'sd7, 32'd5,      1'b1, MID_RGB},
         // tiny span to exercise rounding
         '{32'd0, 32'd3, 32'd1,          1'b0, colour_type'('0)}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, range rewritten whenever a row asks for a new one
      for (i = 0; i < DIR_ROWS; i++) begin
         row = dir_table[i];
         if (row.lo != range_lo || row.hi != range_hi) begin
            wait_drained();
            set_range(row.lo, row.hi);
         end
         send_sample(row.sample, row.typed, row.rgb);
      end

      // random phases, each with its own range and pace
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         sel = (p < 6) ? p : $urandom_range(0, 5);
         new_lo = $urandom;
         case (sel)
            0: begin
               new_lo = S_MIN;
               new_hi = S_MAX;
            end
            1: begin
               new_lo = S_MAX;
               new_hi = S_MIN;
            end
            2:       new_hi = $urandom;
            3:       new_hi = new_lo + $urandom_range(1, 40);
            4:       new_hi = new_lo;
            default: new_hi = new_lo - $urandom_range(1, 40);
         endcase
         set_range(new_lo, new_hi);
         pace = pace_type'(p % 4);
         if (p == 4)
            pressure_go <= 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++)
            send_sample(pick_sample(), 1'b0, colour_type'('0));
      end

      wait_drained();
      if (mismatch_count == 0 && colour_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
rtl/core/tscm_pkg.sv
rtl/core/tscm_prep.sv
rtl/core/tscm_div_cell.sv
rtl/core/tscm_blend.sv
rtl/core/three_stop_colour_map.sv
tb/sv/tb.sv
